FILE: rtl/grcc_pkg.sv
// Shared types, constants and codes for the grid region component counter.
package grcc_pkg;

  localparam int GRCC_MAX_ROWS = 512;
  localparam int GRCC_MAX_COLS = 512;
  localparam int FLD_W = 10;   // coordinate and config field width
  localparam int CNT_W = 20;   // result count width
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } grcc_cfg_reg_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } grcc_req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_Q_RD,
    ST_Q_DRAIN,
    ST_DONE
  } grcc_state_e;

  typedef struct packed {
    logic             req_type;
    logic             pixel;
    logic [FLD_W-1:0] top_row;
    logic [FLD_W-1:0] left_col;
    logic [FLD_W-1:0] bottom_row;
    logic [FLD_W-1:0] right_col;
  } grcc_req_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] component_count;
    logic                    not_ready;
  } grcc_rsp_t;

  // Table port control, shared by all three tables.
  typedef struct packed {
    logic en;
    logic we;
  } grcc_ram_ctl_t;

  // Accumulator step for one corner read.
  typedef struct packed {
    logic clr;
    logic add;
    logic neg;
    logic use_p;
    logic use_v;
    logic use_h;
  } grcc_acc_op_t;

endpackage

FILE: rtl/grcc_sat_ram.sv
// Single-port summed-area table memory with registered read data.
module grcc_sat_ram
  import grcc_pkg::*;
#(
  parameter int AW = 18,
  parameter int DW = 19
) (
  input  logic          clk_i,
  input  grcc_ram_ctl_t ctl_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (ctl_i.we) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/grcc_accum.sv
// Shared add/subtract unit that folds corner reads into the region count.
module grcc_accum
  import grcc_pkg::*;
#(
  parameter int TW = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  grcc_acc_op_t            op_i,
  input  logic [TW-1:0]           p_i,
  input  logic [TW-1:0]           v_i,
  input  logic [TW-1:0]           h_i,
  output logic signed [CNT_W-1:0] acc_o
);

  logic [CNT_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] p_w, v_w, h_w, term;

  // Result is taken modulo 2^CNT_W; zero-extended operands give exact low bits.
  always_comb begin
    p_w  = op_i.use_p ? CNT_W'(p_i) : '0;
    v_w  = op_i.use_v ? CNT_W'(v_i) : '0;
    h_w  = op_i.use_h ? CNT_W'(h_i) : '0;
    term = p_w - v_w - h_w;
    acc_d = acc_q;
    if (op_i.clr) begin
      acc_d = '0;
    end else if (op_i.add) begin
      acc_d = op_i.neg ? (acc_q - term) : (acc_q + term);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = signed'(acc_q);

endmodule

FILE: rtl/grcc_seq.sv
// Sequencer: load counters, row sums, previous-row buffer, corner walk, result register.
module grcc_seq
  import grcc_pkg::*;
#(
  parameter int MAX_ROWS = GRCC_MAX_ROWS,
  parameter int MAX_COLS = GRCC_MAX_COLS,
  parameter int RW = $clog2(MAX_ROWS),
  parameter int CW = $clog2(MAX_COLS),
  parameter int TW = $clog2(MAX_ROWS * MAX_COLS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [FLD_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  grcc_req_t               in_req_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output grcc_rsp_t               out_rsp_o,
  output grcc_ram_ctl_t           ram_ctl_o,
  output logic [RW+CW-1:0]        addr_p_o,
  output logic [RW+CW-1:0]        addr_v_o,
  output logic [RW+CW-1:0]        addr_h_o,
  output logic [TW-1:0]           wdata_p_o,
  output logic [TW-1:0]           wdata_v_o,
  output logic [TW-1:0]           wdata_h_o,
  input  logic [TW-1:0]           rdata_p_i,
  input  logic [TW-1:0]           rdata_v_i,
  input  logic [TW-1:0]           rdata_h_i,
  output grcc_acc_op_t            acc_op_o,
  input  logic signed [CNT_W-1:0] acc_i
);

  localparam int SW   = $clog2(MAX_COLS + 1);
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int CCW  = $clog2(MAX_COLS + 1);
  localparam int RXW  = (RCW > FLD_W) ? RCW : FLD_W;
  localparam int CXW  = (CCW > FLD_W) ? CCW : FLD_W;

  grcc_state_e  state_q, state_d;
  logic [RW-1:0] r0_q, r0_d, rows_last_q, rows_last_d;
  logic [CW-1:0] c0_q, c0_d, cols_last_q, cols_last_d;
  logic          load_done_q, load_done_d;
  logic          prev_pix_q, prev_pix_d;
  logic          pix_q, pix_d;
  logic          above_q;
  logic [SW-1:0] rs_p_q, rs_p_d, rs_v_q, rs_v_d, rs_h_q, rs_h_d;
  logic [RW-1:0] t0_q, t0_d, b0_q, b0_d;
  logic [CW-1:0] l0_q, l0_d, rc0_q, rc0_d;
  logic [1:0]    corner_q, corner_d;
  logic          nr_q, nr_d;
  grcc_acc_op_t  acc_op_q, acc_op_d;
  logic          out_valid_q, out_valid_d;
  grcc_rsp_t     out_rsp_q, out_rsp_d;
  logic          prow_mem [MAX_COLS];

  logic          accept;
  logic          out_free;
  logic          en_p, en_v, en_h;
  logic [SW-1:0] base_p, base_v, base_h;
  logic          above, left;
  logic [RW-1:0] row_p, row_v;
  logic [CW-1:0] col_p, col_h;

  function automatic logic [RW-1:0] clamp_row(input logic [FLD_W-1:0] f,
                                              input logic [RW-1:0] last);
    logic [RXW-1:0] fx;
    fx = RXW'(f) - RXW'(1);
    if (f == '0) return '0;
    else if (fx > RXW'(last)) return last;
    else return RW'(fx);
  endfunction

  function automatic logic [CW-1:0] clamp_col(input logic [FLD_W-1:0] f,
                                              input logic [CW-1:0] last);
    logic [CXW-1:0] fx;
    fx = CXW'(f) - CXW'(1);
    if (f == '0) return '0;
    else if (fx > CXW'(last)) return last;
    else return CW'(fx);
  endfunction

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.req_type == REQ_LOAD) begin
            state_d = load_done_q ? ST_IDLE : ST_LD_RD;
          end else begin
            state_d = load_done_q ? ST_Q_RD : ST_DONE;
          end
        end
      end
      ST_LD_RD:   state_d = ST_LD_WR;
      ST_LD_WR:   state_d = ST_IDLE;
      ST_Q_RD:    state_d = (corner_q == 2'd3) ? ST_Q_DRAIN : ST_Q_RD;
      ST_Q_DRAIN: state_d = ST_DONE;
      ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Query term enables and corner coordinates
  always_comb begin
    en_p  = (t0_q <= b0_q) && (l0_q <= rc0_q);
    en_v  = (t0_q <  b0_q) && (l0_q <= rc0_q);
    en_h  = (t0_q <= b0_q) && (l0_q <  rc0_q);
    row_p = corner_q[1] ? (t0_q - RW'(1)) : b0_q;
    row_v = corner_q[1] ? t0_q : b0_q;
    col_p = corner_q[0] ? (l0_q - CW'(1)) : rc0_q;
    col_h = corner_q[0] ? l0_q : rc0_q;
  end

  // Load datapath: pair bits and running row sums
  always_comb begin
    above  = (r0_q != '0) && above_q;
    left   = (c0_q != '0) && prev_pix_q;
    base_p = (c0_q == '0) ? '0 : rs_p_q;
    base_v = (c0_q == '0) ? '0 : rs_v_q;
    base_h = (c0_q == '0) ? '0 : rs_h_q;
  end

  // Outputs and datapath next values
  always_comb begin
    r0_d        = r0_q;
    c0_d        = c0_q;
    rows_last_d = rows_last_q;
    cols_last_d = cols_last_q;
    load_done_d = load_done_q;
    prev_pix_d  = prev_pix_q;
    pix_d       = pix_q;
    rs_p_d      = rs_p_q;
    rs_v_d      = rs_v_q;
    rs_h_d      = rs_h_q;
    t0_d        = t0_q;
    b0_d        = b0_q;
    l0_d        = l0_q;
    rc0_d       = rc0_q;
    corner_d    = corner_q;
    nr_d        = nr_q;
    acc_op_d    = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    ram_ctl_o   = '0;
    addr_p_o    = {r0_q, c0_q};
    addr_v_o    = {r0_q, c0_q};
    addr_h_o    = {r0_q, c0_q};
    wdata_p_o   = '0;
    wdata_v_o   = '0;
    wdata_h_o   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pix_d        = in_req_i.pixel;
          t0_d         = clamp_row(in_req_i.top_row, rows_last_q);
          b0_d         = clamp_row(in_req_i.bottom_row, rows_last_q);
          l0_d         = clamp_col(in_req_i.left_col, cols_last_q);
          rc0_d        = clamp_col(in_req_i.right_col, cols_last_q);
          nr_d         = !load_done_q;
          corner_d     = '0;
          acc_op_d.clr = 1'b1;
        end
      end
      ST_LD_RD: begin
        // fetch the entry one row up; ignored on the first row
        ram_ctl_o.en = 1'b1;
        addr_p_o     = {r0_q - RW'(1), c0_q};
        addr_v_o     = {r0_q - RW'(1), c0_q};
        addr_h_o     = {r0_q - RW'(1), c0_q};
      end
      ST_LD_WR: begin
        ram_ctl_o.en = 1'b1;
        ram_ctl_o.we = 1'b1;
        rs_p_d       = base_p + SW'(pix_q);
        rs_v_d       = base_v + SW'(pix_q && above);
        rs_h_d       = base_h + SW'(pix_q && left);
        wdata_p_o    = ((r0_q == '0) ? '0 : rdata_p_i) + TW'(rs_p_d);
        wdata_v_o    = ((r0_q == '0) ? '0 : rdata_v_i) + TW'(rs_v_d);
        wdata_h_o    = ((r0_q == '0) ? '0 : rdata_h_i) + TW'(rs_h_d);
        prev_pix_d   = pix_q;
        if (c0_q == cols_last_q) begin
          c0_d = '0;
          if (r0_q == rows_last_q) begin
            load_done_d = 1'b1;
          end else begin
            r0_d = r0_q + RW'(1);
          end
        end else begin
          c0_d = c0_q + CW'(1);
        end
      end
      ST_Q_RD: begin
        ram_ctl_o.en   = 1'b1;
        addr_p_o       = {row_p, col_p};
        addr_v_o       = {row_v, col_p};
        addr_h_o       = {row_p, col_h};
        corner_d       = corner_q + 2'd1;
        // data lands next cycle together with this step
        acc_op_d.add   = 1'b1;
        acc_op_d.neg   = corner_q[1] ^ corner_q[0];
        acc_op_d.use_p = en_p && !(corner_q[1] && (t0_q == '0))
                              && !(corner_q[0] && (l0_q == '0));
        acc_op_d.use_v = en_v && !(corner_q[0] && (l0_q == '0));
        acc_op_d.use_h = en_h && !(corner_q[1] && (t0_q == '0));
      end
      ST_Q_DRAIN: begin
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_rsp_d.component_count = nr_q ? '0 : acc_i;
          out_rsp_d.not_ready       = nr_q;
        end
      end
      default: begin
      end
    endcase

    // config write restarts loading
    if (cfg_we_i) begin
      r0_d        = '0;
      c0_d        = '0;
      load_done_d = 1'b0;
      prev_pix_d  = 1'b0;
      case (cfg_idx_i)
        CFG_ROWS: begin
          if (cfg_data_i == '0) rows_last_d = '0;
          else if (RXW'(cfg_data_i) > RXW'(MAX_ROWS)) rows_last_d = RW'(MAX_ROWS - 1);
          else rows_last_d = RW'(RXW'(cfg_data_i) - RXW'(1));
        end
        CFG_COLS: begin
          if (cfg_data_i == '0) cols_last_d = '0;
          else if (CXW'(cfg_data_i) > CXW'(MAX_COLS)) cols_last_d = CW'(MAX_COLS - 1);
          else cols_last_d = CW'(CXW'(cfg_data_i) - CXW'(1));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r0_q        <= '0;
      c0_q        <= '0;
      rows_last_q <= RW'(MAX_ROWS - 1);
      cols_last_q <= CW'(MAX_COLS - 1);
      load_done_q <= 1'b0;
      prev_pix_q  <= 1'b0;
      corner_q    <= '0;
      acc_op_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      r0_q        <= r0_d;
      c0_q        <= c0_d;
      rows_last_q <= rows_last_d;
      cols_last_q <= cols_last_d;
      load_done_q <= load_done_d;
      prev_pix_q  <= prev_pix_d;
      corner_q    <= corner_d;
      acc_op_q    <= acc_op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q     <= pix_d;
    rs_p_q    <= rs_p_d;
    rs_v_q    <= rs_v_d;
    rs_h_q    <= rs_h_d;
    t0_q      <= t0_d;
    b0_q      <= b0_d;
    l0_q      <= l0_d;
    rc0_q     <= rc0_d;
    nr_q      <= nr_d;
    out_rsp_q <= out_rsp_d;
  end

  // previous-row pixel buffer; entries read on row one are masked off
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LD_RD) begin
      above_q <= prow_mem[c0_q];
    end
    if (state_q == ST_LD_WR) begin
      prow_mem[c0_q] <= pix_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign acc_op_o    = acc_op_q;

  a_load_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_done_q |-> (c0_q <= cols_last_q) && (r0_q <= rows_last_q))
    else $error("load position beyond configured size");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LD_WR |-> $past(state_q) == ST_LD_RD)
    else $error("table write without preceding row-above read");

  a_corner_only_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    corner_q != 2'd0 |-> state_q == ST_Q_RD)
    else $error("corner counter active outside query walk");

  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rsp_q.not_ready |-> out_rsp_q.component_count == '0)
    else $error("not-ready result carries a count");

endmodule

FILE: rtl/grid_region_component_count.sv
// A binary image is loaded one pixel per request in raster order, building three
// summed-area tables (set pixels, vertical set pairs, horizontal set pairs) in
// single-port memories; a rectangle query then returns pixels minus inner pairs.
// A load request reads the table entry one row up, then writes the new entry
// before the next request is taken, since each table has one port. A query
// reads the four rectangle corners from all three tables one corner per cycle
// into a shared accumulator; the result register is loaded after the walk and a
// drain state, or later if the previous result has not been taken. Queries
// before the image is fully loaded return not_ready. Table contents are
// undefined after reset and need no clearing pass.
module grid_region_component_count
  import grcc_pkg::*;
#(
  parameter int MAX_ROWS = GRCC_MAX_ROWS,
  parameter int MAX_COLS = GRCC_MAX_COLS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FLD_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  grcc_req_t            in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output grcc_rsp_t            out_rsp_o
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = RW + CW;
  localparam int TW = $clog2(MAX_ROWS * MAX_COLS + 1);

  grcc_ram_ctl_t           ram_ctl;
  logic [AW-1:0]           addr_p, addr_v, addr_h;
  logic [TW-1:0]           wdata_p, wdata_v, wdata_h;
  logic [TW-1:0]           rdata_p, rdata_v, rdata_h;
  grcc_acc_op_t            acc_op;
  logic signed [CNT_W-1:0] acc;

  grcc_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .CW       (CW),
    .TW       (TW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .ram_ctl_o   (ram_ctl),
    .addr_p_o    (addr_p),
    .addr_v_o    (addr_v),
    .addr_h_o    (addr_h),
    .wdata_p_o   (wdata_p),
    .wdata_v_o   (wdata_v),
    .wdata_h_o   (wdata_h),
    .rdata_p_i   (rdata_p),
    .rdata_v_i   (rdata_v),
    .rdata_h_i   (rdata_h),
    .acc_op_o    (acc_op),
    .acc_i       (acc)
  );

  grcc_sat_ram #(.AW(AW), .DW(TW)) u_pix_tbl (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .addr_i  (addr_p),
    .wdata_i (wdata_p),
    .rdata_o (rdata_p)
  );

  grcc_sat_ram #(.AW(AW), .DW(TW)) u_vert_tbl (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .addr_i  (addr_v),
    .wdata_i (wdata_v),
    .rdata_o (rdata_v)
  );

  grcc_sat_ram #(.AW(AW), .DW(TW)) u_horz_tbl (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .addr_i  (addr_h),
    .wdata_i (wdata_h),
    .rdata_o (rdata_h)
  );

  grcc_accum #(.TW(TW)) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (acc_op),
    .p_i    (rdata_p),
    .v_i    (rdata_v),
    .h_i    (rdata_h),
    .acc_o  (acc)
  );

endmodule

FILE: bench/grid_region_component_count_tb.sv
// Self-checking bench for the grid region component counter: directed table, then random loads and queries.
module grid_region_component_count_tb;
  import grcc_pkg::*;

  localparam int NR = GRCC_MAX_ROWS;
  localparam int NC = GRCC_MAX_COLS;
  localparam int ITEMS = 1800;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [1:0] {SAT_PIX, SAT_VPAIR, SAT_HPAIR} sat_sel_e;
  typedef enum logic {STEP_REQ, STEP_CFG} step_kind_e;

  typedef struct {
    step_kind_e       kind;
    grcc_cfg_reg_e    sel;
    logic [FLD_W-1:0] val;
    grcc_req_t        req;
    bit               typed;
    grcc_rsp_t        want;
  } step_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [FLD_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  grcc_req_t            in_req_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  grcc_rsp_t            out_rsp_o;

  grid_region_component_count uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Predictor state: summed-area tables, load position and image size.
  bit [18:0] pix_sat   [NR*NC];
  bit [17:0] vpair_sat [NR*NC];
  bit [17:0] hpair_sat [NR*NC];
  bit        row_above [NC];
  bit        left_pix;
  int        ld_row, ld_col;
  bit        img_done;
  int        rows_cfg, cols_cfg;

  grcc_rsp_t answers[$];
  int        n_expected = 0;
  int        n_checked = 0;
  int        n_items = 0;
  int        mismatches = 0;
  int        stall_cycles = 0;

  function automatic void flag(string what, integer want, integer got);
    if (mismatches < 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    mismatches++;
  endfunction

  function automatic int clamp_to(logic [FLD_W-1:0] v, int hi);
    int x;
    x = int'(v);
    if (x < 1) return 1;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic void restart_image();
    row_above = '{default: 1'b0};
    left_pix = 1'b0;
    ld_row = 1;
    ld_col = 1;
    img_done = 1'b0;
  endfunction

  function automatic void apply_reg(grcc_cfg_reg_e sel, logic [FLD_W-1:0] v);
    if (sel == CFG_ROWS) rows_cfg = clamp_to(v, NR);
    else cols_cfg = clamp_to(v, NC);
    restart_image();
  endfunction

  // Row or column zero reads as zero.
  function automatic int sat_at(sat_sel_e t, int r, int c);
    int k;
    if (r < 1 || c < 1 || r > NR || c > NC) return 0;
    k = (r - 1) * NC + (c - 1);
    case (t)
      SAT_PIX:   return int'(pix_sat[k]);
      SAT_VPAIR: return int'(vpair_sat[k]);
      default:   return int'(hpair_sat[k]);
    endcase
  endfunction

  function automatic int box_sum(sat_sel_e t, int r0, int c0, int r1, int c1);
    if (r0 > r1 || c0 > c1) return 0;
    return sat_at(t, r1, c1) - sat_at(t, r1, c0 - 1) - sat_at(t, r0 - 1, c1)
         + sat_at(t, r0 - 1, c0 - 1);
  endfunction

  function automatic int prefix(sat_sel_e t, int r, int c, bit term);
    return int'(term) + sat_at(t, r - 1, c) + sat_at(t, r, c - 1) - sat_at(t, r - 1, c - 1);
  endfunction

  function automatic void load_pixel(bit p);
    int r, c, k;
    bit up, lft;
    if (img_done) return;
    r = ld_row;
    c = ld_col;
    up = row_above[c-1];
    lft = (c > 1) ? left_pix : 1'b0;
    k = (r - 1) * NC + (c - 1);
    pix_sat[k]   = 19'(prefix(SAT_PIX, r, c, p));
    vpair_sat[k] = 18'(prefix(SAT_VPAIR, r, c, p & up));
    hpair_sat[k] = 18'(prefix(SAT_HPAIR, r, c, p & lft));
    row_above[c-1] = p;
    left_pix = p;
    if (c >= cols_cfg) begin
      ld_col = 1;
      if (r >= rows_cfg) img_done = 1'b1;
      else ld_row = r + 1;
    end else begin
      ld_col = c + 1;
    end
  endfunction

  function automatic grcc_rsp_t count_region(grcc_req_t q);
    grcc_rsp_t a;
    int t, l, b, rc, n;
    a = '0;
    if (!img_done) begin
      a.not_ready = 1'b1;
      return a;
    end
    t  = clamp_to(q.top_row, rows_cfg);
    l  = clamp_to(q.left_col, cols_cfg);
    b  = clamp_to(q.bottom_row, rows_cfg);
    rc = clamp_to(q.right_col, cols_cfg);
    n = box_sum(SAT_PIX, t, l, b, rc) - box_sum(SAT_VPAIR, t + 1, l, b, rc)
      - box_sum(SAT_HPAIR, t, l + 1, b, rc);
    a.component_count = CNT_W'(n);
    return a;
  endfunction

  function automatic grcc_req_t mk_load(bit p);
    grcc_req_t r;
    r.req_type   = REQ_LOAD;
    r.pixel      = p;
    r.top_row    = FLD_W'($urandom_range(0, 1023));
    r.left_col   = FLD_W'($urandom_range(0, 1023));
    r.bottom_row = FLD_W'($urandom_range(0, 1023));
    r.right_col  = FLD_W'($urandom_range(0, 1023));
    return r;
  endfunction

  function automatic grcc_req_t mk_query(logic [FLD_W-1:0] t, logic [FLD_W-1:0] l,
                                         logic [FLD_W-1:0] b, logic [FLD_W-1:0] rc, bit p);
    grcc_req_t r;
    r.req_type   = REQ_QUERY;
    r.pixel      = p;
    r.top_row    = t;
    r.left_col   = l;
    r.bottom_row = b;
    r.right_col  = rc;
    return r;
  endfunction

  // Mostly in-range rectangles, some reversed, some with raw 10-bit coordinates.
  function automatic grcc_req_t rand_query();
    logic [FLD_W-1:0] t, l, b, rc;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      t  = FLD_W'($urandom_range(0, 1023));
      l  = FLD_W'($urandom_range(0, 1023));
      b  = FLD_W'($urandom_range(0, 1023));
      rc = FLD_W'($urandom_range(0, 1023));
    end else begin
      t  = FLD_W'($urandom_range(1, rows_cfg));
      b  = FLD_W'($urandom_range(1, rows_cfg));
      l  = FLD_W'($urandom_range(1, cols_cfg));
      rc = FLD_W'($urandom_range(1, cols_cfg));
      if (sel < 9 && t > b) {t, b} = {b, t};
      if (sel < 9 && l > rc) {l, rc} = {rc, l};
    end
    return mk_query(t, l, b, rc, 1'($urandom_range(0, 1)));
  endfunction

  function automatic step_t reg_step(grcc_cfg_reg_e sel, logic [FLD_W-1:0] v);
    step_t s;
    s.kind = STEP_CFG;
    s.sel = sel;
    s.val = v;
    s.req = '0;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t req_step(grcc_req_t r);
    step_t s;
    s = reg_step(CFG_ROWS, '0);
    s.kind = STEP_REQ;
    s.req = r;
    return s;
  endfunction

  function automatic step_t fixed(step_t s, logic signed [CNT_W-1:0] cnt, logic nr);
    s.typed = 1'b1;
    s.want.component_count = cnt;
    s.want.not_ready = nr;
    return s;
  endfunction

  function automatic int send_gap_pct();
    if (n_items < ITEMS / 3) return 12;
    if (n_items < 2 * ITEMS / 3) return 69;
    return 0;
  endfunction

  function automatic int recv_gap_pct();
    if (n_items < ITEMS / 3) return 69;
    if (n_items < 2 * ITEMS / 3) return 12;
    return 0;
  endfunction

  // Results still owed; the count taken at this edge is read from the handshake.
  function automatic int pending();
    return n_expected - n_checked - int'(out_valid_o && out_ready_i);
  endfunction

  task automatic issue(input grcc_req_t r, input bit typed = 1'b0, input grcc_rsp_t want = '0);
    if (!(r.req_type == REQ_LOAD && img_done)) n_items++;
    while ($urandom_range(0, 99) < send_gap_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (r.req_type == REQ_QUERY) begin
      answers.push_back(typed ? want : count_region(r));
      n_expected++;
    end else begin
      load_pixel(r.pixel);
    end
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending() > 0);
  endtask

  task automatic write_reg(input grcc_cfg_reg_e sel, input logic [FLD_W-1:0] v);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sel;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(sel, v);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i)
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= recv_gap_pct());

  always @(posedge clk_i) begin
    grcc_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_checked <= n_checked + 1;
      if (answers.size() == 0) begin
        flag("result with no query pending", 0, 1);
      end else begin
        want = answers.pop_front();
        if (out_rsp_o.not_ready !== want.not_ready)
          flag("not_ready", want.not_ready, out_rsp_o.not_ready);
        if (out_rsp_o.component_count !== want.component_count)
          flag("component_count", want.component_count, out_rsp_o.component_count);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    step_t            plan[$];
    int               phase, total, dens, nq, which;
    logic [FLD_W-1:0] rv, cv;

    rows_cfg = NR;
    cols_cfg = NC;
    restart_image();

    // Directed rows: a typed answer where it is obvious, the predictor elsewhere.
    plan.push_back(fixed(req_step(mk_query(1, 1, 512, 512, 1'b0)), 0, 1'b1));
    plan.push_back(reg_step(CFG_ROWS, 0));        // zero taken as one row
    plan.push_back(reg_step(CFG_COLS, 3));
    plan.push_back(req_step(mk_load(1'b1)));
    plan.push_back(req_step(mk_load(1'b1)));
    plan.push_back(fixed(req_step(mk_query(1, 1, 1, 3, 1'b0)), 0, 1'b1));
    plan.push_back(req_step(mk_load(1'b0)));
    plan.push_back(fixed(req_step(mk_query(0, 0, 1023, 1023, 1'b0)), 1, 1'b0));
    plan.push_back(fixed(req_step(mk_query(1, 3, 1, 1, 1'b0)), 0, 1'b0));
    plan.push_back(req_step(mk_load(1'b1)));      // image complete, dropped
    plan.push_back(req_step(mk_query(1, 2, 1, 2, 1'b1)));
    plan.push_back(reg_step(CFG_ROWS, 3));
    plan.push_back(reg_step(CFG_COLS, 2));
    repeat (6) plan.push_back(req_step(mk_load(1'b1)));
    plan.push_back(fixed(req_step(mk_query(1, 1, 3, 2, 1'b0)), -1, 1'b0));
    plan.push_back(req_step(mk_query(2, 1, 3, 1, 1'b0)));
    plan.push_back(req_step(mk_query(3, 2, 2, 2, 1'b0)));
    plan.push_back(reg_step(CFG_ROWS, 1023));     // above the maximum, clamped
    plan.push_back(reg_step(CFG_COLS, 1));
    plan.push_back(fixed(req_step(mk_query(512, 1, 512, 1, 1'b1)), 0, 1'b1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) write_reg(plan[i].sel, plan[i].val);
      else issue(plan[i].req, plan[i].typed, plan[i].want);
    end

    phase = 0;
    while (n_items < ITEMS) begin
      phase++;
      which = 2;
      if (phase == 2) begin
        rv = 1023;
        cv = 1;
      end else if (phase == 4) begin
        rv = 1;
        cv = 512;
      end else begin
        rv = ($urandom_range(0, 19) == 0) ? FLD_W'(0) : FLD_W'($urandom_range(1, 10));
        cv = ($urandom_range(0, 19) == 0) ? FLD_W'(0) : FLD_W'($urandom_range(1, 10));
        which = $urandom_range(0, 4);
      end
      if (which != 1) write_reg(CFG_ROWS, rv);
      if (which != 0) write_reg(CFG_COLS, cv);

      total = rows_cfg * cols_cfg;
      // now and then stop short so the next register write restarts a partial image
      if (phase != 2 && phase != 4 && $urandom_range(0, 7) == 0)
        total = $urandom_range(0, total - 1);
      dens = $urandom_range(5, 95);
      for (int i = 0; i < total; i++) begin
        if ($urandom_range(0, 99) < 8) issue(rand_query());
        issue(mk_load($urandom_range(0, 99) < dens));
        if (phase % 5 == 3 && i == total / 2) wait_results();
      end

      if (img_done) begin
        nq = $urandom_range(6, 20);
        repeat (nq) begin
          if ($urandom_range(0, 9) == 0) issue(mk_load(1'($urandom_range(0, 1))));
          issue(rand_query());
        end
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && answers.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
